[rtl/core/kvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types, constants and helpers of the key/value text tokenizer
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int MAX_BUFFER_BYTES = 65536;
   localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int OFS_W            = 17;
   localparam int MAX_RESULTS      = 3;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W            = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_TDATA_W      = 8;
   localparam int RSP_TUSER_W      = 2;
   localparam int RSP_FIELDS_W     = 2 * OFS_W;
   localparam int RSP_TDATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BUFFER_BYTES);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_COLON = 8'h3a;

   typedef enum logic [1:0] {
      KIND_STRING = 2'd0,
      KIND_NUMBER = 2'd1,
      KIND_COLON  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [OFS_W-1:0]       start_ofs;
      logic [OFS_W-1:0]       end_ofs;
   } entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]                  cnt;
      entry_type [MAX_RESULTS-1:0]       ent;
   } bundle_type;

   function automatic logic [OFS_W-1:0] to_ofs(input logic [POS_W-1:0] pos);
      to_ofs = OFS_W'(pos);
   endfunction

endpackage

[rtl/core/kvt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_front
// per-byte scanner: classifies each request byte and builds its token bundle
// ----------------------------------------------------------------------------
module kvt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           byte_value,
   input  logic                 is_final,
   output logic                 push_valid,
   input  logic                 push_ready,
   output kvt_pkg::bundle_type  push_data
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_BLANK = 3'd1,
      MODE_WORD  = 3'd2,
      MODE_INT   = 3'd3,
      MODE_FRAC  = 3'd4,
      MODE_QUOTE = 3'd5
   } mode_type;

   mode_type                     mode_ff, mode_in;
   logic [kvt_pkg::POS_W-1:0]    tstart_ff, tstart_in;
   logic [kvt_pkg::POS_W-1:0]    pos_ff, pos_in;
   kvt_pkg::bundle_type          bundle;
   logic                         accept;

   function automatic kvt_pkg::bundle_type add_entry(
      input kvt_pkg::bundle_type     b,
      input kvt_pkg::kind_type       k,
      input logic [kvt_pkg::POS_W-1:0] s,
      input logic [kvt_pkg::POS_W-1:0] e
   );
      kvt_pkg::bundle_type r;
      r = b;
      r.ent[b.cnt[kvt_pkg::IDX_W-1:0]] = '{kind: k, start_ofs: kvt_pkg::to_ofs(s),
                                          end_ofs: kvt_pkg::to_ofs(e)};
      r.cnt = b.cnt + 1'b1;
      return r;
   endfunction

   function automatic kvt_pkg::bundle_type close_run(
      input kvt_pkg::bundle_type       b,
      input mode_type                  m,
      input logic [kvt_pkg::POS_W-1:0] s,
      input logic [kvt_pkg::POS_W-1:0] e
   );
      kvt_pkg::bundle_type r;
      r = b;
      if (m == MODE_WORD || m == MODE_QUOTE) begin
         r = add_entry(b, kvt_pkg::KIND_STRING, s, e);
      end else if (m == MODE_INT || m == MODE_FRAC) begin
         r = add_entry(b, kvt_pkg::KIND_NUMBER, s, e);
      end
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_inline_space(input logic [7:0] c);
      return c == kvt_pkg::CH_SPACE || c == kvt_pkg::CH_TAB || c == kvt_pkg::CH_VT ||
             c == kvt_pkg::CH_FF || c == kvt_pkg::CH_CR;
   endfunction

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && (bundle.cnt != '0);
   assign push_data  = bundle;

   always_comb begin
      logic                      taken;
      logic [kvt_pkg::POS_W-1:0] p1;
      logic [kvt_pkg::POS_W-1:0] after;
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      pos_in    = pos_ff;
      bundle    = '0;
      taken     = 1'b0;
      p1        = pos_ff + 1'b1;
      after     = kvt_pkg::MAX_POS;
      if (pos_ff < kvt_pkg::MAX_POS) begin
         unique case (mode_ff)
            MODE_BLANK: begin
               if (is_inline_space(byte_value)) taken = 1'b1;
               else mode_in = MODE_IDLE;
            end
            MODE_WORD: begin
               if (is_letter(byte_value)) begin
                  taken = 1'b1;
               end else begin
                  bundle  = close_run(bundle, mode_ff, tstart_ff, pos_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (is_digit(byte_value)) begin
                  taken = 1'b1;
               end else if (byte_value == kvt_pkg::CH_DOT) begin
                  taken   = 1'b1;
                  mode_in = MODE_FRAC;
               end else begin
                  bundle  = close_run(bundle, mode_ff, tstart_ff, pos_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_FRAC: begin
               if (is_digit(byte_value)) begin
                  taken = 1'b1;
               end else begin
                  bundle  = close_run(bundle, mode_ff, tstart_ff, pos_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_QUOTE: begin
               taken = 1'b1;
               if (byte_value == kvt_pkg::CH_QUOTE) begin
                  bundle  = close_run(bundle, mode_ff, tstart_ff, p1);
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               taken = 1'b0;
            end
         endcase
         if (!taken) begin
            priority if (byte_value == kvt_pkg::CH_NUL) begin
               bundle = add_entry(bundle, kvt_pkg::KIND_END, pos_ff, p1);
            end else if (byte_value == kvt_pkg::CH_SPACE || byte_value == kvt_pkg::CH_TAB) begin
               mode_in = MODE_BLANK;
            end else if (byte_value == kvt_pkg::CH_COLON) begin
               bundle = add_entry(bundle, kvt_pkg::KIND_COLON, pos_ff, p1);
            end else if (byte_value == kvt_pkg::CH_QUOTE) begin
               mode_in   = MODE_QUOTE;
               tstart_in = pos_ff;
            end else if (byte_value == kvt_pkg::CH_MINUS || is_digit(byte_value)) begin
               mode_in   = MODE_INT;
               tstart_in = pos_ff;
            end else if (is_letter(byte_value)) begin
               mode_in   = MODE_WORD;
               tstart_in = pos_ff;
            end else begin
               // newline and unknown bytes
               mode_in = mode_in;
            end
         end
         after = p1;
      end
      pos_in = after;
      if (is_final) begin
         bundle    = close_run(bundle, mode_in, tstart_in, after);
         bundle    = add_entry(bundle, kvt_pkg::KIND_END, after, after);
         mode_in   = MODE_IDLE;
         tstart_in = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         tstart_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         tstart_ff <= tstart_in;
         pos_ff    <= pos_in;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= kvt_pkg::MAX_POS)
      else $error("byte position beyond buffer limit");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && is_final) |-> (push_valid &&
         bundle.ent[bundle.cnt[kvt_pkg::IDX_W-1:0] - 1'b1].kind == kvt_pkg::KIND_END))
      else $error("final byte did not close with an end token");

endmodule

[rtl/core/kvt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_queue
// short bundle queue between the scanner and the result sequencer
// ----------------------------------------------------------------------------
module kvt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  kvt_pkg::bundle_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output kvt_pkg::bundle_type  pop_data
);

   kvt_pkg::bundle_type          slot_ff [kvt_pkg::QUEUE_DEPTH];
   logic [kvt_pkg::QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [kvt_pkg::QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [kvt_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                         do_push, do_pop;

   localparam logic [kvt_pkg::QPTR_W-1:0] LAST_PTR = kvt_pkg::QPTR_W'(kvt_pkg::QUEUE_DEPTH - 1);
   localparam logic [kvt_pkg::QCNT_W-1:0] FULL_CNT = kvt_pkg::QCNT_W'(kvt_pkg::QUEUE_DEPTH);

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + 1'b1;
      if (do_pop)  rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_data;
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue occupancy beyond depth");

   a_no_empty_bundle: assert property (@(posedge clock) disable iff (reset)
      do_push |-> push_data.cnt != '0)
      else $error("empty bundle pushed");

endmodule

[rtl/core/kvt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_back
// result sequencer: plays out each bundle one token per response
// ----------------------------------------------------------------------------
module kvt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  kvt_pkg::bundle_type  pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kvt_pkg::entry_type   rsp_entry,
   output logic                 rsp_last
);

   kvt_pkg::bundle_type          cur_ff;
   logic                         valid_ff;
   logic [kvt_pkg::IDX_W-1:0]    idx_ff;
   logic                         rsp_done;

   assign rsp_valid = valid_ff;
   assign rsp_entry = cur_ff.ent[idx_ff];
   assign rsp_last  = valid_ff && (kvt_pkg::CNT_W'(idx_ff) + 1'b1 == cur_ff.cnt);
   assign rsp_done  = valid_ff && rsp_ready;
   assign pop_ready = !valid_ff || (rsp_done && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
         idx_ff   <= '0;
      end else if (rsp_done) begin
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) cur_ff <= pop_data;
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> kvt_pkg::CNT_W'(idx_ff) < cur_ff.cnt)
      else $error("result index past bundle size");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(idx_ff)))
      else $error("stalled result moved");

endmodule

[rtl/core/key_value_text_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_text_tokenizer_core
// streaming tokenizer for key/value text, one byte per request
//
// req channel: one text byte per request, tdata[7:0] byte_value, tlast marks
// the last byte of a buffer. rsp channel: one token per response, tdata holds
// start and end offsets, tuser the kind; tlast marks the last token of a byte.
// a byte yields zero to three tokens; the end of a buffer always yields an
// end token at the offset just past the last byte and rewinds the offsets.
// a request's bundle is registered in the queue, then in the result sequencer,
// before its first token is offered. throughput: one request per cycle while
// each byte yields at most one token and the response side does not stall;
// the response port sends one token per cycle while rsp_tready is high, so
// bytes with two or three tokens hold it until all are sent and the
// two-entry bundle queue absorbs them. req_tready drops only when that queue
// is full: when the response side stalls or multi-token bytes arrive faster
// than the response port drains them; no token is lost or repeated. reset
// clears scanner state, queue and sequencer directly, with no clearing pass.
// ----------------------------------------------------------------------------
module key_value_text_tokenizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kvt_pkg::REQ_TDATA_W-1:0]   req_tdata,   // byte_value
   input  logic                              req_tlast,   // is_final
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kvt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // start_offset, end_offset
   output logic [kvt_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // kind
   output logic                              rsp_tlast    // last_of_run
);

   logic                 push_valid, push_ready;
   kvt_pkg::bundle_type  push_data;
   logic                 pop_valid, pop_ready;
   kvt_pkg::bundle_type  pop_data;
   kvt_pkg::entry_type   rsp_entry;

   kvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .byte_value (req_tdata[7:0]),
      .is_final   (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   kvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   kvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_entry  (rsp_entry),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(kvt_pkg::RSP_TDATA_W - kvt_pkg::RSP_FIELDS_W){1'b0}},
                       rsp_entry.end_ofs, rsp_entry.start_ofs};
   assign rsp_tuser = rsp_entry.kind;

endmodule
